[design/asd_pkg.sv]
// Shared types, constants and helpers for the ADC sample demux and statistics block.
// No dependencies; every other design file imports this package.
`default_nettype none

package asd_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int SUM_W        = 40;
   localparam int CNT_W        = 16;
   localparam int CH_IDX_W     = 4;
   localparam int CH_CNT_W     = 5;
   localparam int OUT_CH_W     = 3;
   localparam int SHIFT_W      = 5;
   localparam int SHIFT_FIELDS = 8;
   localparam int NUM_CH_W     = 4;
   localparam int ROUNDS_W     = 16;
   localparam int SHIFTS_W     = SHIFT_FIELDS * SHIFT_W;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 40;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFTS       = 2'd2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic signed [SAMPLE_BITS-1:0] HIGH_RESET = 24'sh800000;
   localparam logic signed [SAMPLE_BITS-1:0] LOW_RESET  = 24'sh7FFFFF;
   localparam logic signed [SUM_W:0]         SUM_MAX    = 41'sh007FFFFFFFFF;
   localparam logic signed [SUM_W:0]         SUM_MIN    = -41'sh008000000000;
   localparam logic [CNT_W-1:0]              CNT_MAX    = 16'hFFFF;

   typedef enum logic {
      BK_IDLE,
      BK_REPORT
   } back_state_type;

   typedef struct packed {
      logic [NUM_CH_W-1:0] num_channels;
      logic [ROUNDS_W-1:0] rounds;
      logic [SHIFTS_W-1:0] shifts;
   } cfg_type;

   typedef struct packed {
      logic                          clear;
      logic                          report;
      logic [CH_IDX_W-1:0]           ch;
      logic signed [SAMPLE_BITS-1:0] value;
   } work_type;

   typedef struct packed {
      logic                          kind;
      logic [OUT_CH_W-1:0]           channel;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic signed [SAMPLE_BITS-1:0] high_value;
      logic signed [SAMPLE_BITS-1:0] low_value;
      logic signed [SUM_W-1:0]       sum_value;
      logic [CNT_W-1:0]              sample_count;
      logic                          last;
   } rsp_type;

   // zero counts as one, anything above the build limit is clipped to it
   function automatic logic [CH_CNT_W-1:0] active_channels(
      input logic [NUM_CH_W-1:0] num,
      input logic [CH_CNT_W-1:0] max_ch
   );
      logic [CH_CNT_W-1:0] n;
      n = {1'b0, num};
      if (n == '0) begin
         n = CH_CNT_W'(1);
      end
      if (n > max_ch) begin
         n = max_ch;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[design/asd_req_if.sv]
// Input channel of the ADC sample demux: valid/ready plus one raw sample item.
// Depends on asd_pkg.
`default_nettype none

interface asd_req_if import asd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [SAMPLE_BITS-1:0] sample_bytes;
   logic                   packet_start;

   modport source (output valid, func, sample_bytes, packet_start, input ready);
   modport sink   (input valid, func, sample_bytes, packet_start, output ready);
endinterface

`default_nettype wire

[design/asd_rsp_if.sv]
// Result channel of the ADC sample demux: valid/ready plus one sample or report item.
// Depends on asd_pkg.
`default_nettype none

interface asd_rsp_if import asd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [OUT_CH_W-1:0]           channel;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic signed [SAMPLE_BITS-1:0] high_value;
   logic signed [SAMPLE_BITS-1:0] low_value;
   logic signed [SUM_W-1:0]       sum_value;
   logic [CNT_W-1:0]              sample_count;
   logic                          last;

   modport source (output valid, kind, channel, sample_value, high_value, low_value,
                   sum_value, sample_count, last, input ready);
   modport sink   (input valid, kind, channel, sample_value, high_value, low_value,
                   sum_value, sample_count, last, output ready);
endinterface

`default_nettype wire

[design/adc_sample_demux_stats.sv]
// Top level of the ADC sample demux with per-channel statistics: CSR registers,
// front end, work queue and statistics unit. Depends on asd_pkg and the two channel interfaces.
//
//   port       dir   handshake    item
//   req_chan   in    valid/ready  func, sample_bytes, packet_start
//   rsp_chan   out   valid/ready  sample result or channel report
//   csr_*      in    csr_wr_en    register write, no read-back
//
// One sample item per cycle while the queue has room; each gives a sample result via
// the queue entry and the registered result stage. A report round adds one report per
// active channel in the statistics unit, during which the two-entry queue fills and
// req_chan.ready drops. A clear item resets all channels and gives no result.
// Synchronous reset restores all statistics.
`default_nettype none

module adc_sample_demux_stats import asd_pkg::*; #(
   parameter int MAX_CHANNELS_P = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   asd_req_if.sink                    req_chan,
   asd_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_push;
   work_type q_push_data;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   work_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_CHANNELS: cfg_in.num_channels = csr_wdata[NUM_CH_W-1:0];
            CSR_ROUNDS:       cfg_in.rounds       = csr_wdata[ROUNDS_W-1:0];
            CSR_SHIFTS:       cfg_in.shifts       = csr_wdata[SHIFTS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels <= NUM_CH_W'(1);
         cfg_ff.rounds       <= ROUNDS_W'(100);
         cfg_ff.shifts       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asd_front #(
      .MAX_CHANNELS_P (MAX_CHANNELS_P)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   asd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   asd_back #(
      .MAX_CHANNELS_P (MAX_CHANNELS_P)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .num_channels (cfg_ff.num_channels),
      .q_valid      (q_valid),
      .q_data       (q_head),
      .q_pop        (q_pop),
      .rsp          (rsp_chan)
   );

endmodule

`default_nettype wire

[design/asd_front.sv]
// Front end: accepts items, assigns channels, applies the per-channel shift and
// decides when a report round is due. Depends on asd_pkg and asd_req_if.
`default_nettype none

module asd_front import asd_pkg::*; #(
   parameter int MAX_CHANNELS_P = 8
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   asd_req_if.sink       req,
   input  wire logic     q_full,
   output logic          q_push,
   output work_type      q_data
);

   logic [CH_IDX_W-1:0] idx_ff, idx_in;
   logic [ROUNDS_W-1:0] round_ff, round_in;

   logic [CH_CNT_W-1:0]           nch;
   logic [CH_IDX_W-1:0]           idx_start;
   logic [CH_IDX_W-1:0]           cur;
   logic [CH_CNT_W-1:0]           nxt;
   logic                          wrap;
   logic [SHIFT_W-1:0]            sh_field;
   logic [SHIFT_W-1:0]            sh;
   logic signed [SAMPLE_BITS-1:0] samp;
   logic [SAMPLE_BITS-1:0]        mag;
   logic [SAMPLE_BITS-1:0]        shifted;
   logic signed [SAMPLE_BITS-1:0] value;
   logic [ROUNDS_W-1:0]           rounds;
   logic [ROUNDS_W-1:0]           rc_inc;
   logic                          report;
   logic                          accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      nch       = active_channels(cfg.num_channels, CH_CNT_W'(MAX_CHANNELS_P));
      idx_start = req.packet_start ? '0 : idx_ff;
      cur       = ({1'b0, idx_start} >= nch) ? '0 : idx_start;
      nxt       = {1'b0, cur} + CH_CNT_W'(1);
      wrap      = nxt >= nch;

      sh_field = '0;
      for (int k = 0; k < SHIFT_FIELDS; k++) begin
         if (int'(cur) == k) begin
            sh_field = cfg.shifts[k*SHIFT_W +: SHIFT_W];
         end
      end
      sh = (sh_field > SHIFT_W'(SAMPLE_BITS)) ? SHIFT_W'(SAMPLE_BITS) : sh_field;

      // truncate toward zero: negate, shift, negate back
      samp    = signed'(req.sample_bytes);
      mag     = samp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp) : SAMPLE_BITS'(samp);
      shifted = mag >> sh;
      value   = samp[SAMPLE_BITS-1] ? signed'(SAMPLE_BITS'(-shifted)) : signed'(shifted);

      rounds = (cfg.rounds == '0) ? ROUNDS_W'(1) : cfg.rounds;
      rc_inc = round_ff + ROUNDS_W'(1);
      report = wrap && (rc_inc >= rounds);
   end

   always_comb begin
      idx_in   = idx_ff;
      round_in = round_ff;
      if (accept && !req.func) begin
         idx_in = wrap ? '0 : nxt[CH_IDX_W-1:0];
         if (wrap) begin
            round_in = report ? '0 : rc_inc;
         end
      end
   end

   always_comb begin
      q_push        = accept;
      q_data.clear  = req.func;
      q_data.report = report;
      q_data.ch     = cur;
      q_data.value  = value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         round_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         round_ff <= round_in;
      end
   end

endmodule

`default_nettype wire

[design/asd_queue.sv]
// Two-entry queue of classified work between the front end and the statistics unit.
// Depends on asd_pkg.
`default_nettype none

module asd_queue import asd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   input  wire logic     pop,
   output logic          full,
   output logic          head_valid,
   output work_type      head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   work_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [PTR_W:0]       cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = cnt_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_data  = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? PTR_W'(wr_ff + PTR_W'(1)) : wr_ff;
      rd_in  = do_pop  ? PTR_W'(rd_ff + PTR_W'(1)) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[design/asd_back.sv]
// Statistics unit: per-channel high/low/sum/count, sample results and report rounds,
// behind a registered result stage. Depends on asd_pkg and asd_rsp_if.
`default_nettype none

module asd_back import asd_pkg::*; #(
   parameter int MAX_CHANNELS_P = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [NUM_CH_W-1:0] num_channels,
   input  wire logic                q_valid,
   input  wire work_type            q_data,
   output logic                     q_pop,
   asd_rsp_if.source                rsp
);

   localparam int IW = (MAX_CHANNELS_P > 1) ? $clog2(MAX_CHANNELS_P) : 1;

   back_state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] high_ff  [MAX_CHANNELS_P];
   logic signed [SAMPLE_BITS-1:0] high_in  [MAX_CHANNELS_P];
   logic signed [SAMPLE_BITS-1:0] low_ff   [MAX_CHANNELS_P];
   logic signed [SAMPLE_BITS-1:0] low_in   [MAX_CHANNELS_P];
   logic signed [SUM_W-1:0]       sum_ff   [MAX_CHANNELS_P];
   logic signed [SUM_W-1:0]       sum_in   [MAX_CHANNELS_P];
   logic [CNT_W-1:0]              count_ff [MAX_CHANNELS_P];
   logic [CNT_W-1:0]              count_in [MAX_CHANNELS_P];

   logic [CH_IDX_W-1:0] rep_ff, rep_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [CH_CNT_W-1:0]           nch;
   logic                          out_free;
   logic [IW-1:0]                 wch;
   logic [IW-1:0]                 rch;
   logic                          rep_last;
   logic                          do_clear;
   logic                          do_sample;
   logic                          do_report;
   logic signed [SAMPLE_BITS-1:0] new_high;
   logic signed [SAMPLE_BITS-1:0] new_low;
   logic signed [SUM_W:0]         sum_wide;
   logic signed [SUM_W-1:0]       new_sum;
   logic [CNT_W-1:0]              new_count;

   assign nch      = active_channels(num_channels, CH_CNT_W'(MAX_CHANNELS_P));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign wch      = q_data.ch[IW-1:0];
   assign rch      = rep_ff[IW-1:0];
   assign rep_last = ({1'b0, rep_ff} + CH_CNT_W'(1)) == nch;

   // read-modify-write of the addressed channel
   always_comb begin
      new_high  = (q_data.value > high_ff[wch]) ? q_data.value : high_ff[wch];
      new_low   = (q_data.value < low_ff[wch]) ? q_data.value : low_ff[wch];
      sum_wide  = (SUM_W+1)'(sum_ff[wch]) + (SUM_W+1)'(q_data.value);
      if (sum_wide > SUM_MAX) begin
         new_sum = SUM_MAX[SUM_W-1:0];
      end else if (sum_wide < SUM_MIN) begin
         new_sum = SUM_MIN[SUM_W-1:0];
      end else begin
         new_sum = sum_wide[SUM_W-1:0];
      end
      new_count = (count_ff[wch] == CNT_MAX) ? CNT_MAX : count_ff[wch] + CNT_W'(1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && !q_data.clear && out_free && q_data.report) begin
               state_in = BK_REPORT;
            end
         end
         BK_REPORT: begin
            if (out_free && rep_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      do_clear  = 1'b0;
      do_sample = 1'b0;
      do_report = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            do_clear  = q_valid && q_data.clear;
            do_sample = q_valid && !q_data.clear && out_free;
         end
         BK_REPORT: begin
            do_report = out_free;
         end
         default: ;
      endcase
      q_pop = do_clear || do_sample;
   end

   always_comb begin
      for (int k = 0; k < MAX_CHANNELS_P; k++) begin
         high_in[k]  = high_ff[k];
         low_in[k]   = low_ff[k];
         sum_in[k]   = sum_ff[k];
         count_in[k] = count_ff[k];
         if (do_clear) begin
            high_in[k]  = HIGH_RESET;
            low_in[k]   = LOW_RESET;
            sum_in[k]   = '0;
            count_in[k] = '0;
         end
         if (do_sample && (wch == IW'(k))) begin
            high_in[k]  = new_high;
            low_in[k]   = new_low;
            sum_in[k]   = new_sum;
            count_in[k] = new_count;
         end
         if (do_report && (rch == IW'(k))) begin
            sum_in[k]   = '0;
            count_in[k] = '0;
         end
      end
   end

   always_comb begin
      rep_in       = rep_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      if (do_sample) begin
         rep_in              = '0;
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = KIND_SAMPLE;
         rsp_in.channel      = q_data.ch[OUT_CH_W-1:0];
         rsp_in.sample_value = q_data.value;
         rsp_in.high_value   = new_high;
         rsp_in.low_value    = new_low;
         rsp_in.sum_value    = new_sum;
         rsp_in.sample_count = new_count;
         rsp_in.last         = !q_data.report;
      end else if (do_report) begin
         rep_in              = rep_last ? '0 : rep_ff + CH_IDX_W'(1);
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = KIND_REPORT;
         rsp_in.channel      = rep_ff[OUT_CH_W-1:0];
         rsp_in.sample_value = '0;
         rsp_in.high_value   = high_ff[rch];
         rsp_in.low_value    = low_ff[rch];
         rsp_in.sum_value    = sum_ff[rch];
         rsp_in.sample_count = count_ff[rch];
         rsp_in.last         = rep_last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_CHANNELS_P; k++) begin
            high_ff[k]  <= HIGH_RESET;
            low_ff[k]   <= LOW_RESET;
            sum_ff[k]   <= '0;
            count_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < MAX_CHANNELS_P; k++) begin
            high_ff[k]  <= high_in[k];
            low_ff[k]   <= low_in[k];
            sum_ff[k]   <= sum_in[k];
            count_ff[k] <= count_in[k];
         end
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_ff.kind;
   assign rsp.channel      = rsp_ff.channel;
   assign rsp.sample_value = rsp_ff.sample_value;
   assign rsp.high_value   = rsp_ff.high_value;
   assign rsp.low_value    = rsp_ff.low_value;
   assign rsp.sum_value    = rsp_ff.sum_value;
   assign rsp.sample_count = rsp_ff.sample_count;
   assign rsp.last         = rsp_ff.last;

`ifndef SYNTHESIS
   a_no_pop_in_report: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_REPORT |-> !q_pop)
      else $error("queue popped during a report round");

   a_sample_low_le_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_SAMPLE) |-> (rsp_ff.low_value <= rsp_ff.high_value))
      else $error("sample result with low above high");

   a_sample_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_SAMPLE) |-> (rsp_ff.sample_count != '0))
      else $error("sample result with zero count");

   a_report_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_REPORT && out_free && rep_last) |=>
         (state_ff == BK_IDLE && rsp_valid_ff && rsp_ff.last && rsp_ff.kind == KIND_REPORT))
      else $error("report round did not close with a last report");
`endif

endmodule

`default_nettype wire
